// File: rtl/swtq_pkg.sv
// Shared types and constants for the sorted sleep/wake timer queue.
// No dependencies; every other file in rtl/ imports this package.
package swtq_pkg;

    localparam int DEPTH     = 16;
    localparam int ID_BITS   = 8;
    localparam int TIME_BITS = 63;

    typedef enum logic [1:0] {
        STATUS_ACCEPTED = 2'd0,
        STATUS_REJECTED = 2'd1,
        STATUS_WOKEN    = 2'd2,
        STATUS_NONE_DUE = 2'd3
    } status_t;

    typedef enum logic {
        OP_SLEEP = 1'b0,
        OP_TICK  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SLEEP,
        ST_TICK
    } state_t;

    typedef struct packed {
        op_t                  op;
        logic [7:0]           thread_id;
        logic [TIME_BITS-1:0] time_value;
    } req_t;

    typedef struct packed {
        status_t    status;
        logic [7:0] woken_id;
        logic       last;
    } rsp_t;

    // What one cell shows its neighbors.
    typedef struct packed {
        logic                 valid;
        logic                 keep;      // valid and wake time <= key
        logic [TIME_BITS-1:0] wake_time;
        logic [ID_BITS-1:0]   id;
    } cell_link_t;

    // Chain-wide command, one per cycle.
    typedef struct packed {
        logic insert;
        logic shift;
    } cell_ctrl_t;

endpackage

// File: rtl/swtq_cell.sv
// One slot of the sorted chain: holds one entry, compares it against the key
// and loads the new entry or left/right neighbor data. Depends on swtq_pkg.
module swtq_cell (
    input  logic                            clk,
    input  logic                            rst_n,
    input  swtq_pkg::cell_ctrl_t            ctrl,
    input  logic [swtq_pkg::TIME_BITS-1:0]  key,
    input  logic [swtq_pkg::ID_BITS-1:0]    new_id,
    input  swtq_pkg::cell_link_t            left,
    input  swtq_pkg::cell_link_t            right,
    output swtq_pkg::cell_link_t            self
);
    import swtq_pkg::*;

    logic                 valid_reg, valid_next;
    logic [TIME_BITS-1:0] time_reg, time_next;
    logic [ID_BITS-1:0]   id_reg, id_next;

    always_comb
    begin
        valid_next = valid_reg;
        time_next  = time_reg;
        id_next    = id_reg;
        if (ctrl.insert)
        begin
            priority if (self.keep)
            begin
                // hold: this entry stays ahead of the new one
            end
            else if (left.keep)
            begin
                valid_next = 1'b1;
                time_next  = key;
                id_next    = new_id;
            end
            else
            begin
                valid_next = left.valid;
                time_next  = left.wake_time;
                id_next    = left.id;
            end
        end
        else if (ctrl.shift)
        begin
            valid_next = right.valid;
            time_next  = right.wake_time;
            id_next    = right.id;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        time_reg <= time_next;
        id_reg   <= id_next;
    end

    assign self.valid     = valid_reg;
    assign self.keep      = valid_reg && (time_reg <= key);
    assign self.wake_time = time_reg;
    assign self.id        = id_reg;

endmodule

// File: rtl/sleep_wake_timer_queue_unit.sv
// Top level of the sorted sleep/wake timer queue: request register, control
// sequencer and a chain of swtq_cell slots. Depends on swtq_pkg, swtq_cell.
//
//   channel   ports                 handshake
//   request   req (req_t)           taken when start && !busy
//   result    rsp (rsp_t)           valid for one cycle while rsp_valid
//
// A sleep item is registered, then every cell compares and shifts in
// parallel. A tick item is registered, then due entries leave the chain
// front one per cycle. Results are registered and appear in the cycle
// after the work cycle that produced them.
// Reset empties the chain at once; no clearing pass. The receiver cannot stall.
module sleep_wake_timer_queue_unit (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  swtq_pkg::req_t  req,
    output logic            rsp_valid,
    output swtq_pkg::rsp_t  rsp
);
    import swtq_pkg::*;

    state_t     state_reg, state_next;
    req_t       req_reg, req_next;
    logic       rsp_valid_reg, rsp_valid_next;
    rsp_t       rsp_reg, rsp_next;
    cell_ctrl_t ctrl;

    cell_link_t links [DEPTH];
    cell_link_t left_links [DEPTH];
    cell_link_t right_links [DEPTH];
    logic [DEPTH-1:0] valid_vec;
    logic [DEPTH-1:0] keep_vec;
    logic             cell1_keep;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_chain
            if (g == 0)
            begin : g_head
                assign left_links[g] = '{valid: 1'b1, keep: 1'b1,
                                         wake_time: '0, id: '0};
            end
            else
            begin : g_mid
                assign left_links[g] = links[g-1];
            end
            if (g == DEPTH - 1)
            begin : g_tail
                assign right_links[g] = '0;
            end
            else
            begin : g_body
                assign right_links[g] = links[g+1];
            end

            swtq_cell u_cell (
                .clk    (clk),
                .rst_n  (rst_n),
                .ctrl   (ctrl),
                .key    (req_reg.time_value),
                .new_id (ID_BITS'(req_reg.thread_id)),
                .left   (left_links[g]),
                .right  (right_links[g]),
                .self   (links[g])
            );

            assign valid_vec[g] = links[g].valid;
            assign keep_vec[g]  = links[g].keep;
        end
    endgenerate

    assign cell1_keep = links[1].keep;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        rsp_reg <= rsp_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        rsp_valid_next = 1'b0;
        rsp_next       = rsp_reg;
        ctrl           = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    req_next   = req;
                    state_next = (req.op == OP_TICK) ? ST_TICK : ST_SLEEP;
                end
            end
            ST_SLEEP:
            begin
                rsp_valid_next = 1'b1;
                rsp_next.woken_id = '0;
                rsp_next.last     = 1'b1;
                if (valid_vec[DEPTH-1])
                    rsp_next.status = STATUS_REJECTED;
                else
                begin
                    ctrl.insert     = 1'b1;
                    rsp_next.status = STATUS_ACCEPTED;
                end
                state_next = ST_IDLE;
            end
            ST_TICK:
            begin
                rsp_valid_next = 1'b1;
                // drop the front entry while it is due; the chain only
                // reaches a not-due front here on the first cycle
                if (links[0].keep)
                begin
                    ctrl.shift        = 1'b1;
                    rsp_next.status   = STATUS_WOKEN;
                    rsp_next.woken_id = 8'(links[0].id);
                    rsp_next.last     = !cell1_keep;
                    if (!cell1_keep)
                        state_next = ST_IDLE;
                end
                else
                begin
                    rsp_next.status   = STATUS_NONE_DUE;
                    rsp_next.woken_id = '0;
                    rsp_next.last     = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy      = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // occupied slots form a solid run from the front
    a_fill_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_vec & (valid_vec + 1'b1)) == '0)
        else $error("occupied slots are not contiguous");

    // chain stays sorted, so due slots also form a run from the front
    a_due_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (keep_vec & (keep_vec + 1'b1)) == '0)
        else $error("due slots are not contiguous");

    a_rsp_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> $past(state_reg != ST_IDLE))
        else $error("result without a work cycle");

    a_reject_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status == STATUS_REJECTED) |-> $past(valid_vec[DEPTH-1]))
        else $error("sleep rejected while chain had room");

    a_sleep_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SLEEP && !valid_vec[DEPTH-1])
            |=> $countones(valid_vec) == $countones($past(valid_vec)) + 1)
        else $error("accepted sleep did not add one entry");

endmodule
